// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the 8080 alu and flags unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define AF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("alu and flags unit assertion failed");

// condition in one cycle implies a consequence in the next cycle
`define AF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alu and flags unit assertion failed");

`endif

// ===== rtl/i8080af_pkg.sv =====
// types, codes and helpers shared by the 8080 alu and flags unit
`timescale 1ns / 1ps

package i8080af_pkg;

  // operation codes carried in the input word
  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_ADC = 5'd1,
    OP_SUB = 5'd2,
    OP_SBB = 5'd3,
    OP_ANA = 5'd4,
    OP_XRA = 5'd5,
    OP_ORA = 5'd6,
    OP_CMP = 5'd7,
    OP_INR = 5'd8,
    OP_DCR = 5'd9,
    OP_RLC = 5'd10,
    OP_RRC = 5'd11,
    OP_RAL = 5'd12,
    OP_RAR = 5'd13,
    OP_CMA = 5'd14,
    OP_STC = 5'd15,
    OP_CMC = 5'd16,
    OP_DAD = 5'd17,
    OP_POP = 5'd18,
    OP_LDA = 5'd19
  } op_e;

  // flag bit positions in the packed flag byte
  localparam int unsigned FlagSPos  = 7;
  localparam int unsigned FlagZPos  = 6;
  localparam int unsigned FlagAcPos = 4;
  localparam int unsigned FlagPPos  = 2;
  localparam int unsigned FlagOnePos = 1;
  localparam int unsigned FlagCyPos = 0;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  // architectural state: accumulator and flags
  typedef struct packed {
    logic [7:0] acc;
    flags_t     flags;
  } arch_t;

  // everything one operation produces
  typedef struct packed {
    arch_t       arch;
    logic [7:0]  result_byte;
    logic [15:0] pair_sum;
  } alu_res_t;

  // pack flags into the psw low byte layout
  function automatic logic [7:0] pack_flags(flags_t f);
    logic [7:0] b;
    b             = 8'h00;
    b[FlagSPos]   = f.s;
    b[FlagZPos]   = f.z;
    b[FlagAcPos]  = f.ac;
    b[FlagPPos]   = f.p;
    b[FlagOnePos] = 1'b1;
    b[FlagCyPos]  = f.cy;
    return b;
  endfunction

endpackage

// ===== rtl/i8080_alu_and_flags_unit.sv =====
// top level of the 8080 alu and flags unit: input register, alu, state and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Intel 8080 accumulator ALU with the S, Z, AC, P and CY flags. One input word
// names an operation and its operands; one result word returns the new
// accumulator, the INR/DCR byte, the DAD sum and the packed flag byte. The unit
// has an input register and a result register with the ALU between them. A word
// accepted into the input register moves into the result register as soon as
// that register is free or its result is being taken, and its result is then
// presented until taken. While the receiver keeps up, a new word can be accepted
// every cycle; a stalled result holds the word in the input register, and with
// both registers full the input stalls until the result is taken. The
// accumulator and flags are updated as a word moves into the result register,
// so each word sees the state its predecessor left.
// Accumulator and flags clear to zero at reset.
module i8080_alu_and_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  operation_i,
  input  logic [7:0]  operand_i,
  input  logic [15:0] pair_value_i,
  input  logic [15:0] hl_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  accumulator_o,
  output logic [7:0]  result_byte_o,
  output logic [15:0] pair_sum_o,
  output logic [7:0]  flags_byte_o
);

  logic        in_valid_q;
  logic [4:0]  operation_q;
  logic [7:0]  operand_q;
  logic [15:0] pair_value_q;
  logic [15:0] hl_value_q;
  logic        out_valid_q;
  logic        out_valid_d;
  logic [7:0]  accumulator_q;
  logic [7:0]  result_byte_q;
  logic [15:0] pair_sum_q;
  logic [7:0]  flags_byte_q;
  logic        advance;
  logic        in_take;
  i8080af_pkg::arch_t    arch_q;
  i8080af_pkg::alu_res_t alu_res;

  // handshake: a word moves on when the result stage is free or being taken
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  // input stage word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      operation_q  <= operation_i;
      operand_q    <= operand_i;
      pair_value_q <= pair_value_i;
      hl_value_q   <= hl_value_i;
    end
  end

  i8080af_alu u_alu (
    .op_i      (operation_q),
    .operand_i (operand_q),
    .pair_i    (pair_value_q),
    .hl_i      (hl_value_q),
    .arch_i    (arch_q),
    .res_o     (alu_res)
  );

  i8080af_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (advance),
    .arch_d_i (alu_res.arch),
    .arch_q_o (arch_q)
  );

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result stage word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      accumulator_q <= alu_res.arch.acc;
      result_byte_q <= alu_res.result_byte;
      pair_sum_q    <= alu_res.pair_sum;
      flags_byte_q  <= i8080af_pkg::pack_flags(alu_res.arch.flags);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accumulator_o = accumulator_q;
  assign result_byte_o = result_byte_q;
  assign pair_sum_o    = pair_sum_q;
  assign flags_byte_o  = flags_byte_q;

  // a waiting result always shows the current accumulator
  `AF_ASSERT(a_out_acc_matches_state, !out_valid_o || (accumulator_o == arch_q.acc))
  // a waiting result carries the current flags
  `AF_ASSERT(a_out_flags_match_state,
             !out_valid_o || (flags_byte_o == i8080af_pkg::pack_flags(arch_q.flags)))
  // state changes only when a word retires
  `AF_ASSERT_NEXT(a_state_holds_idle, !advance, $stable(arch_q))
  // a result appears only after a word moved out of the input stage
  `AF_ASSERT(a_out_rise_from_advance, !$rose(out_valid_q) || $past(advance))

endmodule

// ===== rtl/i8080af_alu.sv =====
// combinational 8080 alu: next accumulator, flags and side results for one word
`timescale 1ns / 1ps

module i8080af_alu (
  input  logic [4:0]            op_i,
  input  logic [7:0]            operand_i,
  input  logic [15:0]           pair_i,
  input  logic [15:0]           hl_i,
  input  i8080af_pkg::arch_t    arch_i,
  output i8080af_pkg::alu_res_t res_o
);

  logic [7:0]  a;
  logic        cy;
  logic        sub_op;
  logic        carry_in;
  logic [7:0]  add_b;
  logic        add_cin;
  logic [8:0]  sum9;
  logic [4:0]  nib5;
  logic        cy_arith;
  logic [7:0]  incdec;
  logic [16:0] dad17;

  // sign, zero and even parity of a byte, plus given ac and cy
  function automatic i8080af_pkg::flags_t szp(logic [7:0] v, logic ac, logic c);
    i8080af_pkg::flags_t f;
    f.s  = v[7];
    f.z  = (v == 8'h00);
    f.p  = ~^v;
    f.ac = ac;
    f.cy = c;
    return f;
  endfunction

  assign a  = arch_i.acc;
  assign cy = arch_i.flags.cy;

  // shared byte adder: subtracts run as a + ~b + !borrow
  assign sub_op   = (op_i == i8080af_pkg::OP_SUB) || (op_i == i8080af_pkg::OP_SBB) ||
                    (op_i == i8080af_pkg::OP_CMP);
  assign carry_in = ((op_i == i8080af_pkg::OP_ADC) || (op_i == i8080af_pkg::OP_SBB)) ? cy : 1'b0;
  assign add_b    = sub_op ? ~operand_i : operand_i;
  assign add_cin  = sub_op ? ~carry_in : carry_in;
  assign sum9     = {1'b0, a} + {1'b0, add_b} + {8'h00, add_cin};
  assign nib5     = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};
  assign cy_arith = sub_op ? ~sum9[8] : sum9[8];

  // inr / dcr byte
  assign incdec = (op_i == i8080af_pkg::OP_DCR) ? (operand_i - 8'd1) : (operand_i + 8'd1);

  // 16-bit pair add
  assign dad17 = {1'b0, pair_i} + {1'b0, hl_i};

  // select the effect of the operation
  always_comb begin
    res_o.arch        = arch_i;
    res_o.result_byte = 8'h00;
    res_o.pair_sum    = 16'h0000;
    unique case (i8080af_pkg::op_e'(op_i))
      i8080af_pkg::OP_ADD, i8080af_pkg::OP_ADC,
      i8080af_pkg::OP_SUB, i8080af_pkg::OP_SBB: begin
        res_o.arch.acc   = sum9[7:0];
        res_o.arch.flags = szp(sum9[7:0], nib5[4], cy_arith);
      end
      i8080af_pkg::OP_CMP: begin
        res_o.arch.flags = szp(sum9[7:0], nib5[4], cy_arith);
      end
      i8080af_pkg::OP_ANA: begin
        res_o.arch.acc   = a & operand_i;
        res_o.arch.flags = szp(a & operand_i, a[3] | operand_i[3], 1'b0);
      end
      i8080af_pkg::OP_XRA: begin
        res_o.arch.acc   = a ^ operand_i;
        res_o.arch.flags = szp(a ^ operand_i, 1'b0, 1'b0);
      end
      i8080af_pkg::OP_ORA: begin
        res_o.arch.acc   = a | operand_i;
        res_o.arch.flags = szp(a | operand_i, 1'b0, 1'b0);
      end
      i8080af_pkg::OP_INR: begin
        res_o.result_byte = incdec;
        res_o.arch.flags  = szp(incdec, incdec[3:0] == 4'h0, cy);
      end
      i8080af_pkg::OP_DCR: begin
        res_o.result_byte = incdec;
        res_o.arch.flags  = szp(incdec, incdec[3:0] != 4'hf, cy);
      end
      i8080af_pkg::OP_RLC: begin
        res_o.arch.acc      = {a[6:0], a[7]};
        res_o.arch.flags.cy = a[7];
      end
      i8080af_pkg::OP_RRC: begin
        res_o.arch.acc      = {a[0], a[7:1]};
        res_o.arch.flags.cy = a[0];
      end
      i8080af_pkg::OP_RAL: begin
        res_o.arch.acc      = {a[6:0], cy};
        res_o.arch.flags.cy = a[7];
      end
      i8080af_pkg::OP_RAR: begin
        res_o.arch.acc      = {cy, a[7:1]};
        res_o.arch.flags.cy = a[0];
      end
      i8080af_pkg::OP_CMA: begin
        res_o.arch.acc = ~a;
      end
      i8080af_pkg::OP_STC: begin
        res_o.arch.flags.cy = 1'b1;
      end
      i8080af_pkg::OP_CMC: begin
        res_o.arch.flags.cy = ~cy;
      end
      i8080af_pkg::OP_DAD: begin
        res_o.pair_sum      = dad17[15:0];
        res_o.arch.flags.cy = dad17[16];
      end
      i8080af_pkg::OP_POP: begin
        res_o.arch.acc      = pair_i[15:8];
        res_o.arch.flags.s  = pair_i[i8080af_pkg::FlagSPos];
        res_o.arch.flags.z  = pair_i[i8080af_pkg::FlagZPos];
        res_o.arch.flags.ac = pair_i[i8080af_pkg::FlagAcPos];
        res_o.arch.flags.p  = pair_i[i8080af_pkg::FlagPPos];
        res_o.arch.flags.cy = pair_i[i8080af_pkg::FlagCyPos];
      end
      i8080af_pkg::OP_LDA: begin
        res_o.arch.acc = operand_i;
      end
      default: begin
        res_o.arch = arch_i;
      end
    endcase
  end

endmodule

// ===== rtl/i8080af_state.sv =====
// accumulator and flag register of the 8080 alu
`timescale 1ns / 1ps

module i8080af_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  i8080af_pkg::arch_t arch_d_i,
  output i8080af_pkg::arch_t arch_q_o
);

  i8080af_pkg::arch_t arch_q;
  i8080af_pkg::arch_t arch_d;

  // take the new state only when a word retires into the result stage
  assign arch_d = upd_i ? arch_d_i : arch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q <= '0;
    end else begin
      arch_q <= arch_d;
    end
  end

  assign arch_q_o = arch_q;

endmodule
